// ===== sv/dkar_pkg.sv =====
// ----------------------------------------------------------------------------
// dkar_pkg
// Shared types and constants for the direction key auto-repeat unit.
// ----------------------------------------------------------------------------
package dkar_pkg;

    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 16;
    localparam int STAMP_BITS     = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_REPEAT_DELAY    = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_REPEAT_INTERVAL = 1'd1;

    localparam logic [CFG_DATA_BITS-1:0] REPEAT_DELAY_RESET    = 16'd180;
    localparam logic [CFG_DATA_BITS-1:0] REPEAT_INTERVAL_RESET = 16'd80;

    localparam logic CMD_FRAME   = 1'b0;
    localparam logic CMD_BLOCKED = 1'b1;

    localparam logic MOVE_PRESS  = 1'b0;
    localparam logic MOVE_REPEAT = 1'b1;

    // current direction: 0..3 selects a key, DIR_NONE means nothing selected
    localparam logic [2:0] DIR_NONE = 3'd4;

    // press handling order within one frame: up, left, down, right
    localparam logic [1:0] SCAN_ORDER [4] = '{2'd0, 2'd2, 2'd1, 2'd3};

    typedef struct packed {
        logic                  command;
        logic [3:0]            dir_keys_held;
        logic                  enter_held;
        logic [STAMP_BITS-1:0] time_ms;
        logic [1:0]            blocked_dir;
    } item_t;

    typedef struct packed {
        logic       move_valid;
        logic       move_kind;
        logic [1:0] move_dir;
        logic       enter_pulse;
        logic       enter_release_edge;
        logic [3:0] dir_press_edges;
        logic [3:0] dir_release_edges;
    } result_t;

    typedef struct packed {
        logic [CFG_DATA_BITS-1:0] repeat_delay_ms;
        logic [CFG_DATA_BITS-1:0] repeat_interval_ms;
    } cfg_t;

endpackage

// ===== sv/dkar_ifs.sv =====
// ----------------------------------------------------------------------------
// dkar channel interfaces
// Valid/ready channels for frame samples, results and register writes.
// ----------------------------------------------------------------------------
interface dkar_sample_if;
    logic                            valid;
    logic                            ready;
    logic                            command;
    logic [3:0]                      dir_keys_held;
    logic                            enter_held;
    logic [dkar_pkg::STAMP_BITS-1:0] time_ms;
    logic [1:0]                      blocked_dir;

    modport source (output valid, command, dir_keys_held, enter_held, time_ms,
                    blocked_dir, input ready);
    modport sink (input valid, command, dir_keys_held, enter_held, time_ms,
                  blocked_dir, output ready);
endinterface

interface dkar_result_if;
    logic       valid;
    logic       ready;
    logic       move_valid;
    logic       move_kind;
    logic [1:0] move_dir;
    logic       enter_pulse;
    logic       enter_release_edge;
    logic [3:0] dir_press_edges;
    logic [3:0] dir_release_edges;

    modport source (output valid, move_valid, move_kind, move_dir, enter_pulse,
                    enter_release_edge, dir_press_edges, dir_release_edges,
                    input ready);
    modport sink (input valid, move_valid, move_kind, move_dir, enter_pulse,
                  enter_release_edge, dir_press_edges, dir_release_edges,
                  output ready);
endinterface

interface dkar_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [dkar_pkg::CFG_INDEX_BITS-1:0] index;
    logic [dkar_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/dkar_cfg.sv =====
// ----------------------------------------------------------------------------
// dkar_cfg
// Repeat delay and repeat interval registers behind the write channel.
// ----------------------------------------------------------------------------
module dkar_cfg
(
    input  logic             clk,
    input  logic             rst_n,
    dkar_cfg_if.sink         cfg,
    output dkar_pkg::cfg_t   settings
);

    logic [dkar_pkg::CFG_DATA_BITS-1:0] delay_reg;
    logic [dkar_pkg::CFG_DATA_BITS-1:0] interval_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg    <= dkar_pkg::REPEAT_DELAY_RESET;
            interval_reg <= dkar_pkg::REPEAT_INTERVAL_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == dkar_pkg::REG_REPEAT_DELAY)
            begin
                delay_reg <= cfg.data;
            end
            if (cfg.index == dkar_pkg::REG_REPEAT_INTERVAL)
            begin
                interval_reg <= cfg.data;
            end
        end
    end

    assign settings.repeat_delay_ms    = delay_reg;
    assign settings.repeat_interval_ms = interval_reg;

endmodule

// ===== sv/dkar_engine.sv =====
// ----------------------------------------------------------------------------
// dkar_engine
// Key tracking state and the single-pass frame logic that updates it.
// ----------------------------------------------------------------------------
module dkar_engine
#(
    parameter int TIME_BITS = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  dkar_pkg::item_t   item,
    input  dkar_pkg::cfg_t    settings,
    output dkar_pkg::result_t result
);

    localparam int CMP_BITS = (TIME_BITS > dkar_pkg::CFG_DATA_BITS) ?
                              TIME_BITS : dkar_pkg::CFG_DATA_BITS;

    logic [3:0]           held_prev_reg;
    logic [TIME_BITS-1:0] press_time_reg [4];
    logic [TIME_BITS-1:0] last_rep_reg [4];
    logic [3:0]           blocked_reg;
    logic [2:0]           cur_dir_reg;
    logic                 enter_prev_reg;
    logic                 enter_armed_reg;

    logic [TIME_BITS-1:0] press_time_next [4];
    logic [TIME_BITS-1:0] last_rep_next [4];
    logic [3:0]           blocked_next;
    logic [2:0]           cur_dir_next;
    logic                 enter_armed_next;
    dkar_pkg::result_t    frame_res;

    always_comb
    begin
        logic [TIME_BITS-1:0] now;
        logic [3:0]           held;
        logic [3:0]           pe;
        logic [3:0]           re;
        logic [TIME_BITS-1:0] age_p [4];
        logic [TIME_BITS-1:0] age_l [4];
        logic [2:0]           cur;
        logic [2:0]           best;
        logic [TIME_BITS-1:0] best_age;
        logic [1:0]           d;

        now  = TIME_BITS'(item.time_ms);
        held = item.dir_keys_held;
        pe   = held & ~held_prev_reg;
        re   = ~held & held_prev_reg;

        for (int k = 0; k < 4; k++)
        begin
            press_time_next[k] = pe[k] ? now : press_time_reg[k];
            last_rep_next[k]   = pe[k] ? now : last_rep_reg[k];
            age_p[k]           = now - press_time_next[k];
            age_l[k]           = now - last_rep_next[k];
        end
        blocked_next = blocked_reg & ~(pe | re);

        // presses select, releases deselect only the selected key
        cur = cur_dir_reg;
        for (int i = 0; i < 4; i++)
        begin
            if (pe[dkar_pkg::SCAN_ORDER[i]])
            begin
                cur = {1'b0, dkar_pkg::SCAN_ORDER[i]};
            end
            else if (re[dkar_pkg::SCAN_ORDER[i]] &&
                     cur == {1'b0, dkar_pkg::SCAN_ORDER[i]})
            begin
                cur = dkar_pkg::DIR_NONE;
            end
        end

        // fallback: youngest held key, lowest number on a tie
        best     = dkar_pkg::DIR_NONE;
        best_age = '0;
        for (int k = 0; k < 4; k++)
        begin
            if (held[k] && (best == dkar_pkg::DIR_NONE || age_p[k] < best_age))
            begin
                best     = 3'(k);
                best_age = age_p[k];
            end
        end
        if (cur == dkar_pkg::DIR_NONE)
        begin
            cur = best;
        end

        frame_res                    = '0;
        frame_res.dir_press_edges    = pe;
        frame_res.dir_release_edges  = re;
        frame_res.enter_pulse        = item.enter_held && !enter_prev_reg &&
                                       enter_armed_reg;
        frame_res.enter_release_edge = !item.enter_held && enter_prev_reg;
        enter_armed_next             = enter_armed_reg;
        if (frame_res.enter_pulse)
        begin
            enter_armed_next = 1'b0;
        end
        if (frame_res.enter_release_edge)
        begin
            enter_armed_next = 1'b1;
        end

        d = cur[1:0];
        if (cur != dkar_pkg::DIR_NONE)
        begin
            if (!held[d])
            begin
                cur = dkar_pkg::DIR_NONE;
            end
            else if (!blocked_next[d])
            begin
                if (pe[d])
                begin
                    frame_res.move_valid = 1'b1;
                    frame_res.move_kind  = dkar_pkg::MOVE_PRESS;
                    frame_res.move_dir   = d;
                end
                else if (CMP_BITS'(age_p[d]) >= CMP_BITS'(settings.repeat_delay_ms) &&
                         CMP_BITS'(age_l[d]) >= CMP_BITS'(settings.repeat_interval_ms))
                begin
                    last_rep_next[d]     = now;
                    frame_res.move_valid = 1'b1;
                    frame_res.move_kind  = dkar_pkg::MOVE_REPEAT;
                    frame_res.move_dir   = d;
                end
            end
        end
        cur_dir_next = cur;
    end

    // a blocked note gives an all-zero result
    assign result = (item.command == dkar_pkg::CMD_BLOCKED) ? '0 : frame_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_prev_reg   <= '0;
            blocked_reg     <= '0;
            cur_dir_reg     <= dkar_pkg::DIR_NONE;
            enter_prev_reg  <= 1'b0;
            enter_armed_reg <= 1'b1;
            for (int k = 0; k < 4; k++)
            begin
                press_time_reg[k] <= '0;
                last_rep_reg[k]   <= '0;
            end
        end
        else if (fire)
        begin
            if (item.command == dkar_pkg::CMD_BLOCKED)
            begin
                blocked_reg <= blocked_reg | (4'b0001 << item.blocked_dir);
            end
            else
            begin
                held_prev_reg   <= item.dir_keys_held;
                blocked_reg     <= blocked_next;
                cur_dir_reg     <= cur_dir_next;
                enter_prev_reg  <= item.enter_held;
                enter_armed_reg <= enter_armed_next;
                for (int k = 0; k < 4; k++)
                begin
                    press_time_reg[k] <= press_time_next[k];
                    last_rep_reg[k]   <= last_rep_next[k];
                end
            end
        end
    end

endmodule

// ===== sv/direction_key_autorepeat_unit.sv =====
// path: an accepted item is registered in item_reg, and its result is registered in res_reg
// when the item advances, that is when the result register is free or being emptied
// throughput: one item per cycle; a result stall holds the sample channel in the same cycle
// reset: rst_n clears key tracking state and restores delay 180 ms, interval 80 ms
// ----------------------------------------------------------------------------
// direction_key_autorepeat_unit
// Direction key edge detection, selection and typematic repeat with enter pulse.
// ----------------------------------------------------------------------------
module direction_key_autorepeat_unit
#(
    parameter int TIME_BITS = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    dkar_sample_if.sink   sample,
    dkar_result_if.source result,
    dkar_cfg_if.sink      cfg
);

    dkar_pkg::item_t   item_reg;
    logic              item_valid_reg;
    dkar_pkg::result_t res_reg;
    logic              res_valid_reg;

    dkar_pkg::cfg_t    settings;
    dkar_pkg::result_t step_res;
    logic              advance;

    dkar_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .settings (settings)
    );

    dkar_engine #(.TIME_BITS(TIME_BITS)) u_engine
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (advance),
        .item     (item_reg),
        .settings (settings),
        .result   (step_res)
    );

    // item moves on when the result register is free or being emptied
    assign advance      = item_valid_reg && (!res_valid_reg || result.ready);
    assign sample.ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (sample.ready)
            begin
                item_valid_reg <= sample.valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            item_reg.command       <= sample.command;
            item_reg.dir_keys_held <= sample.dir_keys_held;
            item_reg.enter_held    <= sample.enter_held;
            item_reg.time_ms       <= sample.time_ms;
            item_reg.blocked_dir   <= sample.blocked_dir;
        end
        if (advance)
        begin
            res_reg <= step_res;
        end
    end

    assign result.valid              = res_valid_reg;
    assign result.move_valid         = res_reg.move_valid;
    assign result.move_kind          = res_reg.move_kind;
    assign result.move_dir           = res_reg.move_dir;
    assign result.enter_pulse        = res_reg.enter_pulse;
    assign result.enter_release_edge = res_reg.enter_release_edge;
    assign result.dir_press_edges    = res_reg.dir_press_edges;
    assign result.dir_release_edges  = res_reg.dir_release_edges;

`ifndef SYNTHESIS
    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("result register not loaded after advance");

    a_no_move_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.move_valid) |->
        (result.move_kind == dkar_pkg::MOVE_PRESS && result.move_dir == 2'd0))
        else $error("idle move carries kind or direction");

    a_edges_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ((result.dir_press_edges & result.dir_release_edges) == 4'd0))
        else $error("key pressed and released in the same item");

    a_enter_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.enter_pulse && result.enter_release_edge))
        else $error("enter pulse and release edge together");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !result.ready && !advance) |=> $stable(res_reg))
        else $error("waiting result changed");
`endif

endmodule

// ===== sim/direction_key_autorepeat_unit_tb.sv =====
// ----------------------------------------------------------------------------
// direction_key_autorepeat_unit_tb
// Self-checking bench: frame samples and blocked notes go in through the
// sample channel. A model of the key tracking, repeat timing and enter
// logic gives the event item due for each one, and every result item is
// compared with it field by field. The sender and the receiver idle and
// stall in random bursts.
// ----------------------------------------------------------------------------
module direction_key_autorepeat_unit_tb;

    import dkar_pkg::*;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    localparam logic [1:0] PRESS_ORDER [4] = '{DIR_UP, DIR_LEFT, DIR_DOWN, DIR_RIGHT};

    localparam logic [CFG_DATA_BITS-1:0] DELAY_AT_RESET    = 16'd180;
    localparam logic [CFG_DATA_BITS-1:0] INTERVAL_AT_RESET = 16'd80;

    logic clk;
    logic rst_n;

    dkar_sample_if sample_ch ();
    dkar_result_if result_ch ();
    dkar_cfg_if    cfg_ch ();

    direction_key_autorepeat_unit dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    item_t   pending_frames [$];
    result_t expected_events [$];

    int mismatches = 0;
    bit idle_on    = 1'b1;
    int send_gap   = 0;
    int stall_left = 0;

    // model of the key tracking state
    logic [CFG_DATA_BITS-1:0] delay_ms;
    logic [CFG_DATA_BITS-1:0] interval_ms;
    logic [3:0]               keys_prev;
    logic [STAMP_BITS-1:0]    press_stamp [4];
    logic [STAMP_BITS-1:0]    repeat_stamp [4];
    logic [3:0]               blocked_keys;
    logic [2:0]               sel_dir;
    logic                     enter_prev;
    logic                     enter_armed;

    function automatic void reset_tracking();
        delay_ms     = DELAY_AT_RESET;
        interval_ms  = INTERVAL_AT_RESET;
        keys_prev    = '0;
        blocked_keys = '0;
        sel_dir      = DIR_NONE;
        enter_prev   = 1'b0;
        enter_armed  = 1'b1;
        for (int k = 0; k < 4; k++)
        begin
            press_stamp[k]  = '0;
            repeat_stamp[k] = '0;
        end
    endfunction

    function automatic result_t next_key_events(input item_t frame);
        result_t               ev;
        logic [3:0]            pressed;
        logic [3:0]            released;
        logic [1:0]            d;
        logic [2:0]            best;
        logic [STAMP_BITS-1:0] age;
        logic [STAMP_BITS-1:0] best_age;
        ev = '0;
        if (frame.command == CMD_BLOCKED)
        begin
            blocked_keys[frame.blocked_dir] = 1'b1;
            return ev;
        end
        pressed  = frame.dir_keys_held & ~keys_prev;
        released = ~frame.dir_keys_held & keys_prev;
        for (int k = 0; k < 4; k++)
        begin
            d = PRESS_ORDER[k];
            if (pressed[d])
            begin
                press_stamp[d]  = frame.time_ms;
                repeat_stamp[d] = frame.time_ms;
                blocked_keys[d] = 1'b0;
                sel_dir         = {1'b0, d};
            end
            if (released[d])
            begin
                blocked_keys[d] = 1'b0;
                if (sel_dir == {1'b0, d})
                    sel_dir = DIR_NONE;
            end
        end
        keys_prev = frame.dir_keys_held;

        if (frame.enter_held && !enter_prev && enter_armed)
        begin
            ev.enter_pulse = 1'b1;
            enter_armed    = 1'b0;
        end
        if (!frame.enter_held && enter_prev)
        begin
            ev.enter_release_edge = 1'b1;
            enter_armed           = 1'b1;
        end
        enter_prev = frame.enter_held;

        // fall back to the held key pressed most recently, lowest index on a tie
        if (sel_dir == DIR_NONE)
        begin
            best     = DIR_NONE;
            best_age = '0;
            for (int k = 0; k < 4; k++)
            begin
                age = frame.time_ms - press_stamp[k];
                if (frame.dir_keys_held[k] && (best == DIR_NONE || age < best_age))
                begin
                    best     = 3'(k);
                    best_age = age;
                end
            end
            sel_dir = best;
        end

        if (sel_dir != DIR_NONE)
        begin
            d = sel_dir[1:0];
            if (!frame.dir_keys_held[d])
                sel_dir = DIR_NONE;
            else if (!blocked_keys[d])
            begin
                if (pressed[d])
                begin
                    ev.move_valid = 1'b1;
                    ev.move_kind  = MOVE_PRESS;
                    ev.move_dir   = d;
                end
                else if (STAMP_BITS'(frame.time_ms - press_stamp[d]) >= delay_ms &&
                         STAMP_BITS'(frame.time_ms - repeat_stamp[d]) >= interval_ms)
                begin
                    repeat_stamp[d] = frame.time_ms;
                    ev.move_valid   = 1'b1;
                    ev.move_kind    = MOVE_REPEAT;
                    ev.move_dir     = d;
                end
            end
        end
        ev.dir_press_edges   = pressed;
        ev.dir_release_edges = released;
        return ev;
    endfunction

    task automatic check_field(input string field_name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field_name, want, got);
            mismatches++;
        end
    endtask

    // ---- sample driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sample_ch.valid <= 1'b0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
                expected_events.insert(expected_events.size(),
                                       next_key_events(pending_frames.pop_front()));
            if (sample_ch.valid && !sample_ch.ready)
            begin
                // item still on offer, hold it
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                sample_ch.valid <= 1'b0;
            end
            else if (pending_frames.size() == 0)
            begin
                sample_ch.valid <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                send_gap = $urandom_range(0, 15);
                sample_ch.valid <= 1'b0;
            end
            else
            begin
                sample_ch.valid         <= 1'b1;
                sample_ch.command       <= pending_frames[0].command;
                sample_ch.dir_keys_held <= pending_frames[0].dir_keys_held;
                sample_ch.enter_held    <= pending_frames[0].enter_held;
                sample_ch.time_ms       <= pending_frames[0].time_ms;
                sample_ch.blocked_dir   <= pending_frames[0].blocked_dir;
            end
        end
    end

    // ---- result monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_events.size() == 0)
                begin
                    $error("result item with no expectation waiting");
                    mismatches++;
                end
                else
                begin
                    check_field("move_valid", expected_events[0].move_valid,
                                result_ch.move_valid);
                    check_field("move_kind", expected_events[0].move_kind,
                                result_ch.move_kind);
                    check_field("move_dir", expected_events[0].move_dir,
                                result_ch.move_dir);
                    check_field("enter_pulse", expected_events[0].enter_pulse,
                                result_ch.enter_pulse);
                    check_field("enter_release_edge", expected_events[0].enter_release_edge,
                                result_ch.enter_release_edge);
                    check_field("dir_press_edges", expected_events[0].dir_press_edges,
                                result_ch.dir_press_edges);
                    check_field("dir_release_edges", expected_events[0].dir_release_edges,
                                result_ch.dir_release_edges);
                    void'(expected_events.pop_front());
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 15);
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    task automatic push_frame(input logic [3:0] keys, input logic enter,
                              input logic [STAMP_BITS-1:0] stamp);
        item_t it;
        it.command       = CMD_FRAME;
        it.dir_keys_held = keys;
        it.enter_held    = enter;
        it.time_ms       = stamp;
        it.blocked_dir   = 2'($urandom_range(0, 3));
        pending_frames.insert(pending_frames.size(), it);
    endtask

    // the other fields carry noise, the block ignores them
    task automatic push_block(input logic [1:0] d);
        item_t it;
        it.command       = CMD_BLOCKED;
        it.dir_keys_held = 4'($urandom_range(0, 15));
        it.enter_held    = 1'($urandom_range(0, 1));
        it.time_ms       = $urandom;
        it.blocked_dir   = d;
        pending_frames.insert(pending_frames.size(), it);
    endtask

    task automatic wait_drained();
        while (pending_frames.size() != 0 || sample_ch.valid || expected_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_REPEAT_DELAY)
            delay_ms = value;
        else
            interval_ms = value;
    endtask

    logic [3:0]            keys;
    logic                  enter;
    logic [STAMP_BITS-1:0] now_ms;

    // mostly held keys with one change now and then, so that repeats get reached
    task automatic run_phase(input logic [CFG_DATA_BITS-1:0] delay,
                             input logic [CFG_DATA_BITS-1:0] interval, input int count);
        int roll;
        int step_max;
        wait_drained();
        if ($urandom_range(0, 1))
        begin
            write_register(REG_REPEAT_DELAY, delay);
            write_register(REG_REPEAT_INTERVAL, interval);
        end
        else
        begin
            write_register(REG_REPEAT_INTERVAL, interval);
            write_register(REG_REPEAT_DELAY, delay);
        end
        step_max = (int'(delay) + int'(interval)) / 3 + 4;
        @(negedge clk);
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
            begin
                push_block(2'($urandom_range(0, 3)));
            end
            else
            begin
                if (roll < 14)
                    keys = 4'($urandom_range(0, 15));
                else if (roll < 40)
                    keys[$urandom_range(0, 3)] = ~keys[$urandom_range(0, 3)];
                if ($urandom_range(0, 9) == 0)
                    enter = ~enter;
                if ($urandom_range(0, 49) == 0)
                    now_ms += $urandom;
                else
                    now_ms += $urandom_range(0, step_max);
                push_frame(keys, enter, now_ms);
            end
        end
        wait_drained();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("direction_key_autorepeat_unit verification failed");
        $finish;
    end

    initial
    begin
        rst_n                   = 1'b0;
        sample_ch.valid         = 1'b0;
        sample_ch.command       = CMD_FRAME;
        sample_ch.dir_keys_held = '0;
        sample_ch.enter_held    = 1'b0;
        sample_ch.time_ms       = '0;
        sample_ch.blocked_dir   = DIR_UP;
        result_ch.ready         = 1'b0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.index            = REG_REPEAT_DELAY;
        cfg_ch.data             = '0;
        keys                    = '0;
        enter                   = 1'b0;
        now_ms                  = '0;
        reset_tracking();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed part with the reset delay and interval
        @(negedge clk);
        push_frame(4'b0000, 1'b0, 32'd0);
        push_frame(4'b1111, 1'b1, 32'd10);      // all four at once, right wins
        push_frame(4'b1111, 1'b1, 32'd189);     // one short of the delay
        push_frame(4'b1111, 1'b1, 32'd190);
        push_frame(4'b1111, 1'b1, 32'd269);     // one short of the interval
        push_frame(4'b1111, 1'b1, 32'd270);
        push_frame(4'b0111, 1'b1, 32'd275);     // equal ages, falls back to up
        push_block(DIR_UP);
        push_frame(4'b0111, 1'b1, 32'd400);     // up silenced
        push_frame(4'b0110, 1'b0, 32'd410);     // release clears the block
        push_frame(4'b0111, 1'b1, 32'd420);
        push_frame(4'b0111, 1'b0, 32'd421);
        push_frame(4'b0111, 1'b1, 32'd422);
        push_frame(4'b0111, 1'b1, 32'd423);     // enter still down, no pulse
        push_frame(4'b0000, 1'b0, 32'd430);
        push_frame(4'b0001, 1'b0, 32'hFFFF_FFF0);
        push_block(DIR_UP);
        push_frame(4'b0011, 1'b0, 32'hFFFF_FFF8);
        push_frame(4'b0011, 1'b0, 32'h0000_00A4);
        push_frame(4'b0011, 1'b0, 32'h0000_00AC); // delay reached across the wrap
        push_frame(4'b0000, 1'b0, 32'hFFFF_FFFF);
        push_block(DIR_RIGHT);
        push_frame(4'b1000, 1'b0, 32'd5);       // fresh press clears the block
        push_frame(4'b0100, 1'b1, 32'd6);
        now_ms = 32'd6;
        keys   = 4'b0100;
        enter  = 1'b1;
        wait_drained();

        run_phase(16'd0, 16'd0, 125);
        run_phase(16'hFFFF, 16'hFFFF, 125);
        run_phase(16'd0, 16'd1, 125);
        run_phase(16'($urandom_range(0, 400)), 16'($urandom_range(1, 200)), 125);
        run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(1, 65535)), 125);
        idle_on = 1'b0;
        run_phase(DELAY_AT_RESET, INTERVAL_AT_RESET, 125);

        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_events.size() == 0)
            $display("direction_key_autorepeat_unit verification clean");
        else
            $display("direction_key_autorepeat_unit verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/dkar_pkg.sv
sv/dkar_ifs.sv
sv/dkar_cfg.sv
sv/dkar_engine.sv
sv/direction_key_autorepeat_unit.sv
sim/direction_key_autorepeat_unit_tb.sv
